[rtl/srp_pkg.sv]
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and constants for the shelf rectangle packer.
// ----------------------------------------------------------------------------
package srp_pkg;

	localparam int RECT_W     = 12;
	localparam int PAD_W      = 4;
	localparam int POS_W      = 10;
	localparam int PAGE_OUT_W = 2;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 24;

	localparam logic [PAD_W-1:0] PAD_RST = 4'd1;

	typedef struct packed {
		logic load;
		logic shelf;
		logic fit;
		logic fail;
		logic push;
	} srp_cmd_t;

	typedef struct packed {
		logic reject;
		logic fit_ok;
	} srp_status_t;

endpackage

[rtl/srp_ctrl.sv]
// ----------------------------------------------------------------------------
// srp_ctrl
// Scan sequencer: walks open pages, opens new pages, hands off results.
// ----------------------------------------------------------------------------
module srp_ctrl #(
	parameter int MAX_PAGES = 4,
	parameter int PW        = 2,
	parameter int OW        = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output srp_pkg::srp_cmd_t    cmd,
	input  srp_pkg::srp_status_t status,
	output logic [PW-1:0]        page_idx
);
	import srp_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHELF = 2'd1;
	localparam logic [1:0] ST_FIT   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]    state_q, state_d;
	logic [PW-1:0] page_q, page_d;
	logic          attempt_q, attempt_d;
	logic [OW-1:0] open_q, open_d;
	logic          out_valid_q, out_valid_d;
	logic [OW-1:0] page_nx;
	logic          more, can_open, advance;

	assign page_nx  = OW'(page_q) + OW'(1);
	assign more     = page_nx < open_q;
	assign can_open = open_q < OW'(MAX_PAGES);

	always_comb begin
		state_d     = state_q;
		page_d      = page_q;
		attempt_d   = attempt_q;
		open_d      = open_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		advance     = 1'b0;
		if (out_valid_q && m_tready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					page_d    = '0;
					attempt_d = 1'b0;
					state_d   = ST_SHELF;
				end
			end
			ST_SHELF: begin
				cmd.shelf = 1'b1;
				if (status.reject) begin
					advance = 1'b1;
				end else begin
					state_d = ST_FIT;
				end
			end
			ST_FIT: begin
				cmd.fit = 1'b1;
				if (status.fit_ok) begin
					state_d = ST_DONE;
				end else begin
					advance = 1'b1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.push    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (advance) begin
			if (more) begin
				page_d  = page_nx[PW-1:0];
				state_d = ST_SHELF;
			end else begin
				if (can_open) begin
					open_d = open_q + OW'(1);
				end
				if (!attempt_q && can_open) begin
					attempt_d = 1'b1;
					page_d    = '0;
					state_d   = ST_SHELF;
				end else begin
					cmd.fail = 1'b1;
					state_d  = ST_DONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			page_q      <= '0;
			attempt_q   <= 1'b0;
			open_q      <= OW'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			page_q      <= page_d;
			attempt_q   <= attempt_d;
			open_q      <= open_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign page_idx = page_q;

endmodule

[rtl/srp_dpath.sv]
// ----------------------------------------------------------------------------
// srp_dpath
// Per-page shelf cursors, padding register, shelf/fit checks, result regs.
// ----------------------------------------------------------------------------
module srp_dpath #(
	parameter int PAGE_SIZE = 1024,
	parameter int MAX_PAGES = 4,
	parameter int PW        = 2,
	parameter int CW        = 11,
	parameter int SW        = 14
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [srp_pkg::PAD_W-1:0]       cfg_wr_data,
	input  logic [srp_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic [srp_pkg::M_TDATA_W-1:0]   m_tdata,
	input  srp_pkg::srp_cmd_t               cmd,
	output srp_pkg::srp_status_t            status,
	input  logic [PW-1:0]                   page_idx
);
	import srp_pkg::*;

	localparam logic [SW-1:0] PS = SW'(PAGE_SIZE);

	logic [PAD_W-1:0]  pad_q;
	logic [RECT_W-1:0] h_q;
	logic [SW-1:0]     wp_q, hp_q;
	logic [CW-1:0]     x_q    [MAX_PAGES];
	logic [CW-1:0]     y_q    [MAX_PAGES];
	logic [CW-1:0]     tall_q [MAX_PAGES];
	logic [M_TDATA_W-1:0] res_q, out_q;

	logic [CW-1:0] x_cur, y_cur, tall_cur;
	logic [SW-1:0] sum_x, sum_y, sum_ny, x_new;
	logic [CW-1:0] ny_sat;
	logic          overrun, wide, fit_ok;
	logic [PW+PAGE_OUT_W-1:0] page_ext;
	logic [CW+POS_W-1:0]      px_ext, py_ext;

	assign x_cur    = x_q[page_idx];
	assign y_cur    = y_q[page_idx];
	assign tall_cur = tall_q[page_idx];

	assign sum_x   = SW'(x_cur) + wp_q;
	assign overrun = sum_x > PS;
	assign wide    = wp_q > PS;
	assign sum_ny  = SW'(y_cur) + SW'(tall_cur) + SW'(pad_q);
	assign ny_sat  = (sum_ny > PS) ? CW'(PAGE_SIZE) : sum_ny[CW-1:0];
	assign sum_y   = SW'(y_cur) + hp_q;
	assign fit_ok  = sum_y <= PS;
	assign x_new   = sum_x;

	assign status.reject = overrun && wide;
	assign status.fit_ok = fit_ok;

	assign page_ext = {{PAGE_OUT_W{1'b0}}, page_idx};
	assign px_ext   = {{POS_W{1'b0}}, x_cur};
	assign py_ext   = {{POS_W{1'b0}}, y_cur};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= PAD_RST;
			for (int i = 0; i < MAX_PAGES; i++) begin
				x_q[i]    <= '0;
				y_q[i]    <= '0;
				tall_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				pad_q <= cfg_wr_data;
			end
			if (cmd.shelf && overrun) begin
				y_q[page_idx]    <= ny_sat;
				x_q[page_idx]    <= '0;
				tall_q[page_idx] <= '0;
			end
			if (cmd.fit && fit_ok) begin
				x_q[page_idx] <= x_new[CW-1:0];
				if (SW'(h_q) > SW'(tall_cur)) begin
					tall_q[page_idx] <= h_q[CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			h_q  <= s_tdata[2*RECT_W-1:RECT_W];
			wp_q <= SW'(s_tdata[RECT_W-1:0]) + SW'(pad_q);
			hp_q <= SW'(s_tdata[2*RECT_W-1:RECT_W]) + SW'(pad_q);
		end
		if (cmd.fit && fit_ok) begin
			res_q <= {1'b0, py_ext[POS_W-1:0], px_ext[POS_W-1:0],
				page_ext[PAGE_OUT_W-1:0], 1'b1};
		end else if (cmd.fail) begin
			res_q <= '0;
		end
		if (cmd.push) begin
			out_q <= res_q;
		end
	end

	assign m_tdata = out_q;

endmodule

[rtl/shelf_rect_packer.sv]
// ----------------------------------------------------------------------------
// shelf_rect_packer
// Places rectangles into a multi-page atlas with a shelf scheme.
// ----------------------------------------------------------------------------
// Input stream s_*: one transaction per rectangle request. Output stream m_*:
// one transaction per request, with placed = 0 and zero coordinates when the
// atlas is full or the rectangle is wider than a page. cfg_wr_en/cfg_wr_data
// write the padding register; write it only while no request is in flight.
// Sequence: the request is captured, then each page tried gets a new shelf
// check and then a height fit (only the shelf check when the rectangle is wider
// than a page), then the result is handed off. The worst case is two scans
// covering 2*MAX_PAGES-1 page checks. One request is worked on at a time.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register, so the next request is taken while a result waits; if the
// receiver still stalls when the next result is ready, the sequencer holds it.
// Reset: one page open, all shelf cursors zero, padding 1, no output pending.
// ----------------------------------------------------------------------------
module shelf_rect_packer #(
	parameter int PAGE_SIZE = 1024,
	parameter int MAX_PAGES = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [srp_pkg::PAD_W-1:0]      cfg_wr_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [srp_pkg::S_TDATA_W-1:0]  s_tdata,   // rect_width, rect_height
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [srp_pkg::M_TDATA_W-1:0]  m_tdata    // placed, page, pos_x, pos_y
);
	import srp_pkg::*;

	localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int OW = $clog2(MAX_PAGES + 1);
	localparam int CW = $clog2(PAGE_SIZE + 1);
	localparam int SW = ((CW > RECT_W) ? CW : RECT_W) + 2;

	srp_cmd_t      cmd;
	srp_status_t   status;
	logic [PW-1:0] page_idx;

	srp_ctrl #(
		.MAX_PAGES (MAX_PAGES),
		.PW        (PW),
		.OW        (OW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status),
		.page_idx (page_idx)
	);

	srp_dpath #(
		.PAGE_SIZE (PAGE_SIZE),
		.MAX_PAGES (MAX_PAGES),
		.PW        (PW),
		.CW        (CW),
		.SW        (SW)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.m_tdata     (m_tdata),
		.cmd         (cmd),
		.status      (status),
		.page_idx    (page_idx)
	);

endmodule
